// ===== sv/hmo_pkg.sv =====
// Shared types, constants and the microcode table of the triggered Henon-map oscillator.
package hmo_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int SAMPLE_WIDTH = 24;
  localparam int FRAC_BITS    = VALUE_WIDTH - 4;
  localparam int PROD_WIDTH   = 2 * VALUE_WIDTH;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int IN_DATA_WIDTH   = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELD_WIDTH = 2 * VALUE_WIDTH + 3;
  localparam int OUT_DATA_WIDTH  = ((OUT_FIELD_WIDTH + 7) / 8) * 8;

  // Reset values are held in Q3.28 and rescaled to FRAC_BITS, toward zero.
  localparam int SCALE_UP   = (FRAC_BITS >= 28) ? FRAC_BITS - 28 : 0;
  localparam int SCALE_DOWN = (FRAC_BITS >= 28) ? 0 : 28 - FRAC_BITS;

  localparam logic signed [VALUE_WIDTH-1:0] COEF_A_RESET =
    VALUE_WIDTH'((longint'(375809638) <<< SCALE_UP) / (longint'(1) <<< SCALE_DOWN));
  localparam logic signed [VALUE_WIDTH-1:0] COEF_B_RESET =
    VALUE_WIDTH'((longint'(80530637) <<< SCALE_UP) / (longint'(1) <<< SCALE_DOWN));
  localparam logic signed [VALUE_WIDTH-1:0] FIRST_THR_RESET =
    VALUE_WIDTH'((longint'(50843286) <<< SCALE_UP) / (longint'(1) <<< SCALE_DOWN));
  localparam logic signed [VALUE_WIDTH-1:0] SECOND_THR_RESET =
    VALUE_WIDTH'((longint'(-91108604) <<< SCALE_UP) / (longint'(1) <<< SCALE_DOWN));

  localparam logic signed [VALUE_WIDTH-1:0] FIX_ONE =
    VALUE_WIDTH'(longint'(1) <<< FRAC_BITS);
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_COEF_A     = 3'd0,
    REG_COEF_B     = 3'd1,
    REG_FIRST_THR  = 3'd2,
    REG_SECOND_THR = 3'd3,
    REG_START_X    = 3'd4,
    REG_START_Y    = 3'd5
  } cfg_reg_t;

  // Request kinds carried on the input tuser.
  localparam logic REQ_TRIGGER = 1'b0;
  localparam logic REQ_RESTORE = 1'b1;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] coef_a;
    logic signed [VALUE_WIDTH-1:0] coef_b;
    logic signed [VALUE_WIDTH-1:0] first_thr;
    logic signed [VALUE_WIDTH-1:0] second_thr;
    logic signed [VALUE_WIDTH-1:0] start_x;
    logic signed [VALUE_WIDTH-1:0] start_y;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] x;
    logic signed [VALUE_WIDTH-1:0] y;
    logic                          pulse_one;
    logic                          pulse_two;
  } map_state_t;

  // Multiplier operand selection.
  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_XX   = 2'd1,
    MUL_BX   = 2'd2,
    MUL_AT   = 2'd3
  } mul_sel_t;

  localparam int STEP_WIDTH = 3;
  typedef logic [STEP_WIDTH-1:0] step_t;

  localparam step_t STEP_SQUARE  = 3'd0;
  localparam step_t STEP_BX      = 3'd1;
  localparam step_t STEP_AT      = 3'd2;
  localparam step_t STEP_UPDATE  = 3'd3;
  localparam step_t STEP_PULSE   = 3'd4;
  localparam step_t STEP_EMIT    = 3'd5;
  localparam step_t STEP_RESTORE = 3'd6;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     ld_temp;      // keep the saturated square
    logic     ld_new_y;     // keep b*x
    logic     ld_map;       // write the new point
    logic     ld_pulse;     // update both pulses from the new point
    logic     ld_start;     // reload the start point
    logic     emit;         // hand a result to the output register
    logic     jump_no_rise; // jump to target when the trigger did not rise
    logic     last;         // final word of the program
    step_t    target;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{mul_sel: MUL_NONE, target: STEP_SQUARE, default: 1'b0};

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = CTRL_NOP;
    case (step)
      STEP_SQUARE: begin
        w.mul_sel      = MUL_XX;
        w.jump_no_rise = 1'b1;
        w.target       = STEP_EMIT;
      end
      STEP_BX: begin
        w.mul_sel = MUL_BX;
        w.ld_temp = 1'b1;
      end
      STEP_AT: begin
        w.mul_sel  = MUL_AT;
        w.ld_new_y = 1'b1;
      end
      STEP_UPDATE: begin
        w.ld_map = 1'b1;
      end
      STEP_PULSE: begin
        w.ld_pulse = 1'b1;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.last = 1'b1;
      end
      STEP_RESTORE: begin
        w.ld_start = 1'b1;
        w.last     = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/triggered_henon_map_oscillator.sv =====
// Top level of the triggered Henon-map oscillator: ports, registers and result buffer.
//
// Use: each request on the s_axis side is either a trigger sample (tuser low,
// the signed sample in tdata) or a restore request (tuser high). A trigger
// sample that is strictly greater than the previous one advances the map once,
// x' = 1 - a*x*x + y and y' = b*x in saturating signed fixed point, and then
// refreshes the two fixed-point pulses. Every trigger sample yields one result
// on the m_axis side: x, y, the sign of x and both pulses. A restore request
// reloads x and y from the start registers and yields no result.
// Timing: a rising sample passes the square, b*x, a*s, update, pulse and emit
// steps in turn and reaches the result register at the emit step; the next
// request is taken only after that, as the single shared multiplier forms
// x*x, b*x and a*s in turn under a short microcode program. A sample that does
// not rise goes from the square step straight to the emit step; a restore
// request holds the sequencer for its restore step only.
// s_axis_tready is high whenever the sequencer is idle, so a new request is
// taken while a finished result still waits in the output register. If the
// receiver stalls, the sequencer holds at its emit step until the register is
// free. Reset clears the map point, the pulses and the previous sample and
// loads the default registers; the always-ready configuration port should only
// be written while the block is idle, and unknown indexes are ignored.
module triggered_henon_map_oscillator (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input requests.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [hmo_pkg::IN_DATA_WIDTH-1:0]    s_axis_tdata,  // [23:0] trig_sample
  input  logic                                 s_axis_tuser,  // [0] req_type
  // Results.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [31:0] x_value, [63:32] y_value, [64] x_sign_high, [65] first_pulse,
  // [66] second_pulse, rest zero.
  output logic [hmo_pkg::OUT_DATA_WIDTH-1:0]   m_axis_tdata,
  // Configuration writes.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hmo_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [hmo_pkg::VALUE_WIDTH-1:0]      cfg_data
);

  localparam int VW = hmo_pkg::VALUE_WIDTH;

  hmo_pkg::cfg_regs_t  cfg;
  hmo_pkg::ctrl_t      ctrl;
  hmo_pkg::map_state_t map_state;
  logic                busy;
  logic                accept;
  logic                out_free;
  logic                out_valid;
  logic [hmo_pkg::OUT_DATA_WIDTH-1:0] out_data;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;
  // The result register is free when empty or being drained this cycle.
  assign out_free      = !out_valid || m_axis_tready;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_a     <= hmo_pkg::COEF_A_RESET;
      cfg.coef_b     <= hmo_pkg::COEF_B_RESET;
      cfg.first_thr  <= hmo_pkg::FIRST_THR_RESET;
      cfg.second_thr <= hmo_pkg::SECOND_THR_RESET;
      cfg.start_x    <= '0;
      cfg.start_y    <= '0;
    end else if (cfg_valid) begin
      case (hmo_pkg::cfg_reg_t'(cfg_index))
        hmo_pkg::REG_COEF_A:     cfg.coef_a     <= cfg_data;
        hmo_pkg::REG_COEF_B:     cfg.coef_b     <= cfg_data;
        hmo_pkg::REG_FIRST_THR:  cfg.first_thr  <= cfg_data;
        hmo_pkg::REG_SECOND_THR: cfg.second_thr <= cfg_data;
        hmo_pkg::REG_START_X:    cfg.start_x    <= cfg_data;
        hmo_pkg::REG_START_Y:    cfg.start_y    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hmo_sequencer u_sequencer (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req_restore (s_axis_tuser == hmo_pkg::REQ_RESTORE),
    .trig_sample (s_axis_tdata[hmo_pkg::SAMPLE_WIDTH-1:0]),
    .out_free    (out_free),
    .busy        (busy),
    .ctrl        (ctrl)
  );

  hmo_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .map_state (map_state)
  );

  // Result register; the emit step loads it only when it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_data <= hmo_pkg::OUT_DATA_WIDTH'({map_state.pulse_two,
                                            map_state.pulse_one,
                                            !map_state.x[VW-1],
                                            map_state.y,
                                            map_state.x});
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ===== sv/hmo_sequencer.sv =====
// Step counter, trigger edge detection and microcode fetch for the oscillator.
module hmo_sequencer (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     accept,
  input  logic                                     req_restore,
  input  logic signed [hmo_pkg::SAMPLE_WIDTH-1:0]  trig_sample,
  input  logic                                     out_free,
  output logic                                     busy,
  output hmo_pkg::ctrl_t                           ctrl
);

  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

  seq_state_t                              state;
  hmo_pkg::step_t                          pc;
  logic                                    rise;
  logic signed [hmo_pkg::SAMPLE_WIDTH-1:0] last_trigger;
  hmo_pkg::ctrl_t                          word;
  logic                                    fire;

  assign word = hmo_pkg::ucode(pc);
  // Only the emit step can stall, and only while the output register is full and not being drained.
  assign fire = (state == SEQ_RUN) && (!word.emit || out_free);
  assign busy = (state == SEQ_RUN);

  always_comb begin
    ctrl = word;
    if (!fire) begin
      ctrl = hmo_pkg::CTRL_NOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= SEQ_IDLE;
      pc           <= hmo_pkg::STEP_SQUARE;
      rise         <= 1'b0;
      last_trigger <= '0;
    end else begin
      case (state)
        SEQ_IDLE: begin
          if (accept) begin
            state <= SEQ_RUN;
            if (req_restore) begin
              pc <= hmo_pkg::STEP_RESTORE;
            end else begin
              pc           <= hmo_pkg::STEP_SQUARE;
              rise         <= trig_sample > last_trigger;
              last_trigger <= trig_sample;
            end
          end
        end
        SEQ_RUN: begin
          if (fire) begin
            if (word.last) begin
              state <= SEQ_IDLE;
            end else if (word.jump_no_rise && !rise) begin
              pc <= word.target;
            end else begin
              pc <= pc + 1'b1;
            end
          end
        end
        default: begin
          state <= SEQ_IDLE;
        end
      endcase
    end
  end

  a_restore_entry: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_IDLE && accept && req_restore) |=> (pc == hmo_pkg::STEP_RESTORE))
    else $error("restore request did not enter the restore step");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> out_free)
    else $error("result emitted into a full output register");

  a_update_needs_rise: assert property (@(posedge clk) disable iff (rst)
    (ctrl.ld_map || ctrl.ld_pulse) |-> rise)
    else $error("map advanced without a rising trigger");

endmodule

// ===== sv/hmo_datapath.sv =====
// Shared multiplier, saturation and map state of the oscillator.
module hmo_datapath (
  input  logic                clk,
  input  logic                rst,
  input  hmo_pkg::ctrl_t      ctrl,
  input  hmo_pkg::cfg_regs_t  cfg,
  output hmo_pkg::map_state_t map_state
);

  localparam int VW = hmo_pkg::VALUE_WIDTH;
  localparam int PW = hmo_pkg::PROD_WIDTH;
  localparam int FB = hmo_pkg::FRAC_BITS;
  localparam int SW = VW + 2;

  // Scale a full product back to the value format, rounding down, and clamp.
  function automatic logic signed [VW-1:0] sat_prod(input logic signed [PW-1:0] p);
    logic [PW-FB-VW:0] hi;
    hi = p[PW-1:FB+VW-1];
    if (&hi || ~|hi) begin
      return p[FB+VW-1:FB];
    end else if (p[PW-1]) begin
      return hmo_pkg::VAL_MIN;
    end else begin
      return hmo_pkg::VAL_MAX;
    end
  endfunction

  logic signed [VW-1:0] map_x;
  logic signed [VW-1:0] map_y;
  logic                 pulse_one;
  logic                 pulse_two;
  logic signed [PW-1:0] prod;
  logic signed [VW-1:0] temp;
  logic signed [VW-1:0] new_y;
  logic signed [VW-1:0] op_a;
  logic signed [VW-1:0] op_b;
  logic signed [VW-1:0] prod_sat;
  logic signed [SW-1:0] sum;
  logic signed [VW-1:0] new_x;

  always_comb begin
    case (ctrl.mul_sel)
      hmo_pkg::MUL_XX: begin
        op_a = map_x;
        op_b = map_x;
      end
      hmo_pkg::MUL_BX: begin
        op_a = cfg.coef_b;
        op_b = map_x;
      end
      hmo_pkg::MUL_AT: begin
        op_a = cfg.coef_a;
        op_b = temp;
      end
      default: begin
        op_a = map_x;
        op_b = map_x;
      end
    endcase
  end

  assign prod_sat = sat_prod(prod);

  // x' = 1 - a*x*x + y: the sum of the clamped product and y is formed exactly and clamped once.
  always_comb begin
    sum = SW'(hmo_pkg::FIX_ONE) - SW'(prod_sat) + SW'(map_y);
    if (&sum[SW-1:VW-1] || ~|sum[SW-1:VW-1]) begin
      new_x = sum[VW-1:0];
    end else if (sum[SW-1]) begin
      new_x = hmo_pkg::VAL_MIN;
    end else begin
      new_x = hmo_pkg::VAL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_sel != hmo_pkg::MUL_NONE) begin
      prod <= PW'(op_a) * PW'(op_b);
    end
    if (ctrl.ld_temp) begin
      temp <= prod_sat;
    end
    if (ctrl.ld_new_y) begin
      new_y <= prod_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_x     <= '0;
      map_y     <= '0;
      pulse_one <= 1'b0;
      pulse_two <= 1'b0;
    end else begin
      if (ctrl.ld_start) begin
        map_x <= cfg.start_x;
        map_y <= cfg.start_y;
      end else if (ctrl.ld_map) begin
        map_x <= new_x;
        map_y <= new_y;
      end
      if (ctrl.ld_pulse) begin
        if (!map_x[VW-1]) begin
          pulse_one <= map_y >= cfg.first_thr;
          pulse_two <= 1'b0;
        end else begin
          pulse_one <= 1'b0;
          pulse_two <= map_y >= cfg.second_thr;
        end
      end
    end
  end

  assign map_state.x         = map_x;
  assign map_state.y         = map_y;
  assign map_state.pulse_one = pulse_one;
  assign map_state.pulse_two = pulse_two;

endmodule

// ===== sim/tb_triggered_henon_map_oscillator.sv =====
// Self-checking testbench for the triggered Henon-map oscillator.
`timescale 1ns / 100ps

module tb_triggered_henon_map_oscillator;

  localparam int VW  = hmo_pkg::VALUE_WIDTH;
  localparam int SW  = hmo_pkg::SAMPLE_WIDTH;
  localparam int CIW = hmo_pkg::CFG_INDEX_WIDTH;

  // Fixed-point limits as wide integers. The predictor works in longint, which
  // holds every exact product while VALUE_WIDTH stays at 32 or below.
  localparam longint VAL_HI = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VAL_LO = -VAL_HI - 1;
  localparam longint ONE_Q  = longint'(1) <<< hmo_pkg::FRAC_BITS;
  localparam int     Q_UNIT = 1 << hmo_pkg::FRAC_BITS;

  localparam int SMP_HI = (1 << (SW - 1)) - 1;
  localparam int SMP_LO = -SMP_HI - 1;
  localparam int STEP_SPAN = 4096;

  // Register indexes outside the list; writes to them must change nothing.
  localparam logic [CIW-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CIW-1:0] IDX_SPARE_HI = 3'd7;

  localparam int IDLE_PCT     = 23;    // chance per cycle that a side idles
  localparam int CALM_FROM    = 800;   // window in which neither side idles
  localparam int CALM_TO      = 1100;
  localparam int HOLD_AT      = 300;   // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 16;    // comfortably above the time a request spends in the block
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 320;
  localparam int STALL_LIMIT  = 4000;

  // One result as the block reports it.
  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic                 x_pos;
    logic                 first_up;
    logic                 second_up;
  } point_t;

  // One row of the directed opening; want is used only where typed is set.
  typedef struct packed {
    logic                 kind;
    logic signed [SW-1:0] sample;
    logic                 typed;
    point_t               want;
  } row_t;

  logic clk;
  logic rst;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [hmo_pkg::IN_DATA_WIDTH-1:0]   s_axis_tdata;
  logic                                s_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [hmo_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [CIW-1:0]                      cfg_index;
  logic [VW-1:0]                       cfg_data;

  triggered_henon_map_oscillator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // The testbench's own copy of the registers and of the orbit.
  logic signed [VW-1:0] k_a, k_b, thr_first, thr_second, home_x, home_y;
  logic signed [VW-1:0] orbit_x, orbit_y;
  logic signed [SW-1:0] last_smp;
  logic                 flag_first, flag_second;

  point_t pending_points[$];   // results still owed by the block, oldest first
  row_t   opening[$];

  int errors;
  int requests_sent, results_seen, reg_writes;
  int advances, holds, restores, pinned;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Saturate an exact value to the signed value range.
  function automatic logic signed [VW-1:0] clamp(input longint v);
    if (v > VAL_HI) return VW'(VAL_HI);
    if (v < VAL_LO) return VW'(VAL_LO);
    return VW'(v);
  endfunction

  // Fixed-point product: the arithmetic shift floors towards minus infinity.
  function automatic logic signed [VW-1:0] fx_mul(
    input logic signed [VW-1:0] p,
    input logic signed [VW-1:0] q
  );
    longint prod;
    prod = longint'(p) * longint'(q);
    return clamp(prod >>> hmo_pkg::FRAC_BITS);
  endfunction

  // Advances the predicted orbit for one accepted request. Returns 1 when the
  // request yields a result, which is then left in pt.
  function automatic bit henon_step(
    input  logic                 kind,
    input  logic signed [SW-1:0] smp,
    output point_t               pt
  );
    logic signed [VW-1:0] sq, ax2, nx, ny;
    pt = '0;
    if (kind == hmo_pkg::REQ_RESTORE) begin
      // The previous sample and both pulses survive a restore.
      orbit_x = home_x;
      orbit_y = home_y;
      restores++;
      return 1'b0;
    end
    if (smp > last_smp) begin
      sq  = fx_mul(orbit_x, orbit_x);
      ax2 = fx_mul(k_a, sq);
      nx  = clamp(ONE_Q - longint'(ax2) + longint'(orbit_y));
      ny  = fx_mul(k_b, orbit_x);
      orbit_x = nx;
      orbit_y = ny;
      if (nx >= 0) begin
        flag_first  = (ny >= thr_first);
        flag_second = 1'b0;
      end else begin
        flag_first  = 1'b0;
        flag_second = (ny >= thr_second);
      end
      advances++;
    end else begin
      holds++;
    end
    last_smp = smp;
    if (longint'(orbit_x) == VAL_HI || longint'(orbit_x) == VAL_LO ||
        longint'(orbit_y) == VAL_HI || longint'(orbit_y) == VAL_LO) begin
      pinned++;
    end
    pt.x         = orbit_x;
    pt.y         = orbit_y;
    pt.x_pos     = (orbit_x >= 0);
    pt.first_up  = flag_first;
    pt.second_up = flag_second;
    return 1'b1;
  endfunction

  // Offers one request and waits for it to be taken. Valid stays high after
  // acceptance, so back-to-back requests never lower and raise it in one step.
  task automatic offer(
    input logic                 kind,
    input logic signed [SW-1:0] smp,
    input logic                 typed,
    input point_t               want
  );
    logic [hmo_pkg::IN_DATA_WIDTH-1:0] word;
    point_t                            pt;
    word = '0;
    word[SW-1:0] = smp;
    while (!(requests_sent >= CALM_FROM && requests_sent < CALM_TO) &&
           $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
    if (henon_step(kind, smp, pt)) begin
      pending_points.push_back(typed ? want : pt);
    end
  endtask

  // Writes one register and mirrors it in the predictor. The caller lowers
  // cfg_valid after the last write of a batch.
  task automatic write_reg(
    input logic [CIW-1:0] idx,
    input logic [VW-1:0]  value
  );
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    case (idx)
      hmo_pkg::REG_COEF_A:     k_a        = value;
      hmo_pkg::REG_COEF_B:     k_b        = value;
      hmo_pkg::REG_FIRST_THR:  thr_first  = value;
      hmo_pkg::REG_SECOND_THR: thr_second = value;
      hmo_pkg::REG_START_X:    home_x     = value;
      hmo_pkg::REG_START_Y:    home_y     = value;
      default: ;
    endcase
  endtask

  task automatic load_regs(
    input logic [VW-1:0] a,
    input logic [VW-1:0] b,
    input logic [VW-1:0] t1,
    input logic [VW-1:0] t2,
    input logic [VW-1:0] sx,
    input logic [VW-1:0] sy
  );
    write_reg(hmo_pkg::REG_COEF_A, a);
    write_reg(hmo_pkg::REG_COEF_B, b);
    write_reg(hmo_pkg::REG_FIRST_THR, t1);
    write_reg(hmo_pkg::REG_SECOND_THR, t2);
    write_reg(hmo_pkg::REG_START_X, sx);
    write_reg(hmo_pkg::REG_START_Y, sy);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every owed result has arrived, then lets a restore that
  // yields nothing finish inside the block before anything else happens.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic plan(
    input logic                 kind,
    input logic signed [SW-1:0] smp,
    input logic                 typed,
    input logic signed [VW-1:0] wx,
    input logic signed [VW-1:0] wy,
    input logic [2:0]           wflags
  );
    row_t r;
    r.kind   = kind;
    r.sample = smp;
    r.typed  = typed;
    r.want   = {wx, wy, wflags};
    opening.push_back(r);
  endtask

  task automatic check_field(
    input string         what,
    input logic [VW-1:0] want,
    input logic [VW-1:0] got
  );
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Result checker: every accepted result is matched with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    point_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: result %h arrived with nothing expected, got %h", $time,
                 m_axis_tdata, m_axis_tdata);
      end else begin
        want = pending_points.pop_front();
        check_field("x_value", want.x, m_axis_tdata[VW-1:0]);
        check_field("y_value", want.y, m_axis_tdata[2*VW-1:VW]);
        check_field("x_sign_high", want.x_pos, m_axis_tdata[2*VW]);
        check_field("first_pulse", want.first_up, m_axis_tdata[2*VW+1]);
        check_field("second_pulse", want.second_up, m_axis_tdata[2*VW+2]);
      end
    end
  end

  // Receiver: random back-pressure, a calm window, and one long hold-off
  // while the sender keeps offering, so the block fills up and stalls its input.
  initial begin
    bit held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= (results_seen >= CALM_FROM && results_seen < CALM_TO) ||
                       ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: ends the run when nothing at all is accepted for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no request, result or write accepted for %0d cycles", $time, quiet);
    $display("tb: failure");
    $finish;
  end

  // Main sequence: reset, directed opening, then phases of random requests,
  // each under its own register setting.
  initial begin
    int roll, p, n;
    logic signed [SW-1:0] smp;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= hmo_pkg::REQ_TRIGGER;
    cfg_valid     <= 1'b0;
    cfg_index     <= hmo_pkg::REG_COEF_A;
    cfg_data      <= '0;

    errors = 0;
    requests_sent = 0;
    results_seen = 0;
    reg_writes = 0;
    advances = 0;
    holds = 0;
    restores = 0;
    pinned = 0;

    // State after reset: default coefficients and thresholds, origin, no pulses.
    k_a         = hmo_pkg::COEF_A_RESET;
    k_b         = hmo_pkg::COEF_B_RESET;
    thr_first   = hmo_pkg::FIRST_THR_RESET;
    thr_second  = hmo_pkg::SECOND_THR_RESET;
    home_x      = '0;
    home_y      = '0;
    orbit_x     = '0;
    orbit_y     = '0;
    last_smp    = '0;
    flag_first  = 1'b0;
    flag_second = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening under the reset defaults. The flags column reads
    // {x_sign_high, first_pulse, second_pulse}.
    // A zero sample equals the reset sample, so the origin is reported as is.
    plan(hmo_pkg::REQ_TRIGGER, 24'sd0, 1'b1, '0, '0, 3'b100);
    // First rise from the origin: x becomes exactly one, y stays zero.
    plan(hmo_pkg::REQ_TRIGGER, 24'sd1, 1'b1, VW'(ONE_Q), '0, 3'b100);
    // An equal sample is not a rise.
    plan(hmo_pkg::REQ_TRIGGER, 24'sd1, 1'b1, VW'(ONE_Q), '0, 3'b100);
    plan(hmo_pkg::REQ_TRIGGER, 24'sd2, 1'b0, '0, '0, 3'b000);
    plan(hmo_pkg::REQ_TRIGGER, SW'(SMP_HI), 1'b0, '0, '0, 3'b000);
    plan(hmo_pkg::REQ_TRIGGER, SW'(SMP_HI), 1'b0, '0, '0, 3'b000);
    plan(hmo_pkg::REQ_TRIGGER, SW'(SMP_LO), 1'b0, '0, '0, 3'b000);
    plan(hmo_pkg::REQ_TRIGGER, SW'(SMP_LO + 1), 1'b0, '0, '0, 3'b000);
    // Restore to the origin; the sample field of a restore is ignored.
    plan(hmo_pkg::REQ_RESTORE, 24'sh5a5a5a, 1'b0, '0, '0, 3'b000);
    // The previous sample survives the restore, so this is a rise from it.
    plan(hmo_pkg::REQ_TRIGGER, SW'(SMP_LO + 2), 1'b1, VW'(ONE_Q), '0, 3'b100);
    plan(hmo_pkg::REQ_RESTORE, 24'sha5a5a5, 1'b0, '0, '0, 3'b000);
    // Falling sample straight after a restore: the origin with pulses kept.
    plan(hmo_pkg::REQ_TRIGGER, SW'(SMP_LO), 1'b1, '0, '0, 3'b100);
    for (int k = 1; k <= 10; k++) begin
      plan(hmo_pkg::REQ_TRIGGER, SW'(k * 1000), 1'b0, '0, '0, 3'b000);
    end
    foreach (opening[i]) begin
      offer(opening[i].kind, opening[i].sample, opening[i].typed, opening[i].want);
    end

    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        1: begin
          // Extremes: most negative a, most positive b, thresholds at the top and bottom of the range.
          load_regs(hmo_pkg::VAL_MIN, hmo_pkg::VAL_MAX, hmo_pkg::VAL_MAX,
                    hmo_pkg::VAL_MIN, hmo_pkg::VAL_MAX, hmo_pkg::VAL_MIN);
        end
        2, 5: begin
          // Near the classic attractor, with writes to the spare indexes first.
          write_reg(IDX_SPARE_LO, $urandom);
          write_reg(IDX_SPARE_HI, $urandom);
          load_regs(VW'(int'($urandom_range(Q_UNIT / 2, Q_UNIT * 3 / 2))),
                    VW'(int'($urandom_range(0, Q_UNIT * 6 / 10)) - Q_UNIT * 3 / 10),
                    VW'(int'($urandom_range(0, Q_UNIT)) - Q_UNIT / 2),
                    VW'(int'($urandom_range(0, Q_UNIT)) - Q_UNIT / 2),
                    VW'(int'($urandom_range(0, Q_UNIT)) - Q_UNIT / 2),
                    VW'(int'($urandom_range(0, Q_UNIT)) - Q_UNIT / 2));
        end
        3: begin
          // The opposite extremes.
          load_regs(hmo_pkg::VAL_MAX, hmo_pkg::VAL_MIN, hmo_pkg::VAL_MIN,
                    hmo_pkg::VAL_MAX, hmo_pkg::VAL_MIN, hmo_pkg::VAL_MAX);
        end
        4: begin
          load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        default: ;
      endcase

      // Mostly rising runs so the orbit keeps moving, with falls, level
      // repeats, full-range samples and restores mixed in.
      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 6) begin
          offer(hmo_pkg::REQ_RESTORE, SW'($urandom), 1'b0, '0);
        end else if (roll < 16 || (roll >= 30 && int'(last_smp) > SMP_HI - STEP_SPAN)) begin
          offer(hmo_pkg::REQ_TRIGGER, SW'($urandom), 1'b0, '0);
        end else if (roll < 30) begin
          if (int'(last_smp) < SMP_LO + STEP_SPAN) smp = last_smp;
          else smp = SW'(int'(last_smp) - int'($urandom_range(0, STEP_SPAN)));
          offer(hmo_pkg::REQ_TRIGGER, smp, 1'b0, '0);
        end else begin
          smp = SW'(int'(last_smp) + int'($urandom_range(1, STEP_SPAN)));
          offer(hmo_pkg::REQ_TRIGGER, smp, 1'b0, '0);
        end
      end
    end

    // Drain: every owed result must arrive before the watchdog runs out.
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);

    $display("tb: %0d requests (%0d map advances, %0d level or falling, %0d restores)",
             requests_sent, advances, holds, restores);
    $display("tb: %0d results checked, %0d at a range limit, %0d register writes, %0d errors",
             results_seen, pinned, reg_writes, errors);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
